// ===== design/dlps_pkg.sv =====
`timescale 1ns / 1ps

package dlps_pkg;

    // sizes of the fixed pattern rom
    localparam int PATTERN_COUNT = 18;
    localparam int MAX_PHASES    = 10;
    localparam int NUM_SEQS      = 15;

    // breathing duty scale
    localparam int MAX_DUTY = 255;
    localparam int DUTY_CAP = (MAX_DUTY > 255) ? 255 : MAX_DUTY;
    localparam int DUTY_W   = $clog2(MAX_DUTY + 1);

    // field and counter widths
    localparam int PAT_W   = 5;
    localparam int PHASE_W = 4;
    localparam int SEQ_W   = 4;
    localparam int EL_W    = 22;
    localparam int MS_W    = 16;
    localparam int NUM_W   = MS_W + DUTY_W;
    localparam int CNT_W   = $clog2(NUM_W + 1);

    localparam logic [EL_W-1:0]  ELAPSED_MAX = {EL_W{1'b1}};
    localparam logic [MS_W-1:0]  MS_MAX      = {MS_W{1'b1}};
    localparam logic [PAT_W-1:0] BOOT_PATTERN = '0;

    typedef logic [PAT_W-1:0]   pat_id_t;
    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [SEQ_W-1:0]   seq_id_t;

    // command codes
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SELECT  = 2'd1,
        OP_TRIGGER = 2'd2
    } opcode_t;

    // configuration register indexes
    localparam logic CFG_FLASH_LEN   = 1'b0;
    localparam logic CFG_BREATH_PER  = 1'b1;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EXEC  = 6'b000010,
        ST_MOD   = 6'b000100,
        ST_SCALE = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // one led channel of the phase engine
    typedef struct packed {
        phase_t          phase;
        logic [EL_W-1:0] elapsed;
        logic            level;
    } chan_t;

    // phase lists: length, durations in ms, on bit per phase (bit i = phase i)
    localparam logic [PHASE_W-1:0] SEQ_LEN [NUM_SEQS] = '{
        4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd2, 4'd2, 4'd4, 4'd2, 4'd4, 4'd6, 4'd10
    };

    localparam logic [EL_W-1:0] SEQ_DUR [NUM_SEQS][MAX_PHASES] = '{
        '{22'd3600000, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd3600000, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd100, 22'd100, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd500, 22'd500, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd800, 22'd800, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd700, 22'd700, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd700, 22'd700, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd150, 22'd150, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd150, 22'd150, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd4850, 22'd150, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd100, 22'd100, 22'd100, 22'd1700, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd200, 22'd1800, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd200, 22'd200, 22'd200, 22'd1400, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd200, 22'd200, 22'd200, 22'd200, 22'd200, 22'd1200,
          22'd0, 22'd0, 22'd0, 22'd0},
        '{22'd200, 22'd200, 22'd200, 22'd200, 22'd200, 22'd200,
          22'd200, 22'd200, 22'd200, 22'd800}
    };

    localparam logic [MAX_PHASES-1:0] SEQ_ON [NUM_SEQS] = '{
        10'b0000000001, 10'b0000000000, 10'b0000000001, 10'b0000000001,
        10'b0000000001, 10'b0000000001, 10'b0000000010, 10'b0000000001,
        10'b0000000010, 10'b0000000010, 10'b0000000101, 10'b0000000001,
        10'b0000000101, 10'b0000010101, 10'b0101010101
    };

    // patterns: phase list of each led and the breathing flag
    localparam logic [SEQ_W-1:0] PAT_S1 [PATTERN_COUNT] = '{
        4'd2, 4'd3, 4'd0, 4'd5, 4'd0, 4'd0, 4'd1, 4'd4, 4'd4,
        4'd7, 4'd2, 4'd3, 4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1
    };

    localparam logic [SEQ_W-1:0] PAT_S2 [PATTERN_COUNT] = '{
        4'd2, 4'd1, 4'd1, 4'd6, 4'd9, 4'd2, 4'd1, 4'd0, 4'd10,
        4'd8, 4'd2, 4'd3, 4'd1, 4'd0, 4'd11, 4'd12, 4'd13, 4'd14
    };

    localparam logic [PATTERN_COUNT-1:0] PAT_BREATH = 18'b000001000000000000;

    // phase index that is valid for the list, else the first phase
    function automatic phase_t safe_phase(seq_id_t s, phase_t ph);
        return (ph < SEQ_LEN[s]) ? ph : '0;
    endfunction

    // on bit of a phase
    function automatic logic phase_on(seq_id_t s, phase_t ph);
        logic [MAX_PHASES-1:0] bits;
        bits = SEQ_ON[s];
        return bits[ph];
    endfunction

    // one millisecond of a channel: count, and step to the next phase when due
    function automatic chan_t ch_advance(seq_id_t s, chan_t c);
        chan_t           r;
        phase_t          p;
        logic [EL_W-1:0] e;
        p = safe_phase(s, c.phase);
        e = (c.elapsed != ELAPSED_MAX) ? c.elapsed + 1'b1 : c.elapsed;
        r.phase   = p;
        r.elapsed = e;
        r.level   = c.level;
        if (e >= SEQ_DUR[s][p]) begin
            r.phase   = safe_phase(s, p + 1'b1);
            r.elapsed = '0;
            r.level   = phase_on(s, r.phase);
        end
        return r;
    endfunction

endpackage

// ===== design/dual_led_pattern_sequencer.sv =====
`timescale 1ns / 1ps

// Two-channel LED pattern sequencer. Each input word is a 1 ms tick, a pattern
// select or an activity flash trigger, and each one returns exactly one result
// word with the LED levels after it. Reset loads the boot pattern (pattern 0).
// Steps: an item whose result leaves LED1 breathing (no flash pending and a
// nonzero half period) goes from idle through execute, 2*24 divider steps with
// the scaling state between the two passes, and the output state back to idle;
// any other item goes from execute straight to the output state. The result word
// is offered at the same edge that raises s_ready again. The breathing duty is produced by a
// single restoring divider, one quotient bit per cycle, used twice: once for
// the time modulo the period and once for the duty scaling. s_ready is low
// while an item is in flight; a new item may be accepted while the previous
// result word still waits on m_ready, and the output cycle stalls until that
// word has gone.
module dual_led_pattern_sequencer (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic                      cfg_addr,
    input  logic [dlps_pkg::MS_W-1:0] cfg_wdata,
    // command words
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_opcode,
    input  logic [4:0]                s_pattern_index,
    // result words
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_led1_on,
    output logic                      m_led2_on,
    output logic [7:0]                m_led1_duty,
    output logic                      m_led1_pwm_mode
);
    import dlps_pkg::*;

    state_t            state_reg;
    logic [MS_W-1:0]   flash_len_reg;
    logic [MS_W-1:0]   period_reg;

    pat_id_t           cur_pat_reg,  cur_pat_next;
    chan_t             ch1_reg,      ch1_next;
    chan_t             ch2_reg,      ch2_next;
    logic              pend_reg,     pend_next;
    logic [MS_W-1:0]   act_el_reg,   act_el_next;
    logic              breath_reg,   breath_next;
    logic [MS_W-1:0]   btime_reg,    btime_next;

    logic [1:0]        op_reg;
    pat_id_t           idx_reg;

    logic [MS_W-1:0]   rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [MS_W-1:0]   dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic              m_valid_reg;
    logic              m_led1_on_reg;
    logic              m_led2_on_reg;
    logic [7:0]        m_led1_duty_reg;
    logic              m_led1_pwm_mode_reg;

    seq_id_t           seq_a;
    seq_id_t           seq_b;
    seq_id_t           sel_a;
    seq_id_t           sel_b;
    logic [MS_W:0]     btime_inc;
    logic [MS_W-1:0]   act_inc;
    logic [MS_W-1:0]   half;
    logic              need_duty;
    logic [MS_W:0]     div_shift;
    logic              div_fits;
    logic [MS_W:0]     div_diff;
    logic [MS_W-1:0]   div_rem;
    logic [NUM_W-1:0]  div_quo;
    logic [MS_W-1:0]   scale_x;
    logic [NUM_W-1:0]  scale_num;
    logic [7:0]        duty_val;
    logic              out_free;

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_led1_on       = m_led1_on_reg;
    assign m_led2_on       = m_led2_on_reg;
    assign m_led1_duty     = m_led1_duty_reg;
    assign m_led1_pwm_mode = m_led1_pwm_mode_reg;

    assign half     = period_reg >> 1;
    assign out_free = !m_valid_reg || m_ready;

    // pattern engine: state after the captured command
    always_comb begin
        seq_a        = PAT_S1[cur_pat_reg];
        seq_b        = PAT_S2[cur_pat_reg];
        sel_a        = PAT_S1[0];
        sel_b        = PAT_S2[0];
        btime_inc    = {1'b0, btime_reg} + 1'b1;
        act_inc      = (act_el_reg != MS_MAX) ? act_el_reg + 1'b1 : act_el_reg;
        cur_pat_next = cur_pat_reg;
        ch1_next     = ch1_reg;
        ch2_next     = ch2_reg;
        pend_next    = pend_reg;
        act_el_next  = act_el_reg;
        breath_next  = breath_reg;
        btime_next   = btime_reg;
        unique case (op_reg)
            OP_TICK: begin
                if (breath_reg) begin
                    btime_next = (btime_inc >= {1'b0, period_reg}) ? '0 : btime_inc[MS_W-1:0];
                end
                if (pend_reg) begin
                    act_el_next = act_inc;
                    if (!breath_reg && ch1_reg.elapsed != ELAPSED_MAX) begin
                        ch1_next.elapsed = ch1_reg.elapsed + 1'b1;
                    end
                    if (act_inc >= flash_len_reg) begin
                        pend_next      = 1'b0;
                        ch1_next.phase = safe_phase(seq_a, ch1_reg.phase);
                        ch1_next.level = phase_on(seq_a, ch1_next.phase);
                    end
                end else if (!breath_reg) begin
                    ch1_next = ch_advance(seq_a, ch1_reg);
                end
                ch2_next = ch_advance(seq_b, ch2_reg);
            end
            OP_SELECT: begin
                if (idx_reg < PAT_W'(PATTERN_COUNT) && idx_reg != cur_pat_reg) begin
                    sel_a        = PAT_S1[idx_reg];
                    sel_b        = PAT_S2[idx_reg];
                    cur_pat_next = idx_reg;
                    ch1_next     = '{phase: '0, elapsed: '0, level: phase_on(sel_a, '0)};
                    ch2_next     = '{phase: '0, elapsed: '0, level: phase_on(sel_b, '0)};
                    pend_next    = 1'b0;
                    act_el_next  = '0;
                    btime_next   = '0;
                    breath_next  = PAT_BREATH[idx_reg];
                end
            end
            OP_TRIGGER: begin
                pend_next   = 1'b1;
                act_el_next = '0;
            end
            default: ;
        endcase
        need_duty = !pend_next && breath_next && (half != '0);
    end

    // one restoring divider step
    always_comb begin
        div_shift = {rem_reg, quo_reg[NUM_W-1]};
        div_fits  = (div_shift >= {1'b0, dvs_reg});
        div_diff  = div_shift - {1'b0, dvs_reg};
        div_rem   = div_fits ? div_diff[MS_W-1:0] : div_shift[MS_W-1:0];
        div_quo   = {quo_reg[NUM_W-2:0], div_fits};
    end

    // triangle numerator from the time within the period
    always_comb begin
        scale_x   = (rem_reg < half) ? rem_reg : period_reg - rem_reg;
        scale_num = NUM_W'(scale_x) * NUM_W'(MAX_DUTY);
    end

    // clamped duty
    always_comb begin
        if (half == '0) begin
            duty_val = '0;
        end else if (quo_reg > NUM_W'(DUTY_CAP)) begin
            duty_val = 8'(DUTY_CAP);
        end else begin
            duty_val = quo_reg[7:0];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_len_reg <= MS_W'(50);
            period_reg    <= MS_W'(3000);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_FLASH_LEN:  flash_len_reg <= cfg_wdata;
                CFG_BREATH_PER: period_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer, engine state and divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cur_pat_reg <= BOOT_PATTERN;
            ch1_reg     <= '{phase: '0, elapsed: '0, level: phase_on(PAT_S1[0], '0)};
            ch2_reg     <= '{phase: '0, elapsed: '0, level: phase_on(PAT_S2[0], '0)};
            pend_reg    <= 1'b0;
            act_el_reg  <= '0;
            breath_reg  <= PAT_BREATH[0];
            btime_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // the output cycle sets the word itself
            if (m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_opcode;
                        idx_reg   <= s_pattern_index;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    cur_pat_reg <= cur_pat_next;
                    ch1_reg     <= ch1_next;
                    ch2_reg     <= ch2_next;
                    pend_reg    <= pend_next;
                    act_el_reg  <= act_el_next;
                    breath_reg  <= breath_next;
                    btime_reg   <= btime_next;
                    rem_reg     <= '0;
                    quo_reg     <= NUM_W'(btime_next);
                    dvs_reg     <= period_reg;
                    cnt_reg     <= CNT_W'(NUM_W - 1);
                    state_reg   <= need_duty ? ST_MOD : ST_DONE;
                end
                ST_MOD: begin
                    rem_reg <= div_rem;
                    quo_reg <= div_quo;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    rem_reg   <= '0;
                    quo_reg   <= scale_num;
                    dvs_reg   <= half;
                    cnt_reg   <= CNT_W'(NUM_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= div_rem;
                    quo_reg <= div_quo;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_led2_on_reg <= ch2_reg.level;
            priority if (pend_reg) begin
                m_led1_on_reg       <= 1'b1;
                m_led1_duty_reg     <= '0;
                m_led1_pwm_mode_reg <= 1'b0;
            end else if (breath_reg) begin
                m_led1_on_reg       <= 1'b0;
                m_led1_duty_reg     <= duty_val;
                m_led1_pwm_mode_reg <= 1'b1;
            end else begin
                m_led1_on_reg       <= ch1_reg.level;
                m_led1_duty_reg     <= '0;
                m_led1_pwm_mode_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // geometry of the pattern rom as seen by the predictor
    localparam int NUM_PATTERNS  = 18;
    localparam int NUM_LISTS     = 15;
    localparam int LIST_DEPTH    = 10;
    localparam int CHARGING_PAT  = 12;
    localparam int DUTY_FULL     = 255;
    localparam logic [21:0] EL_SAT   = 22'h3FFFFF;
    localparam logic [15:0] FLASH_SAT = 16'hFFFF;

    // opcode 3 is not decoded by the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // run control
    localparam int RAND_PER_PHASE = 125;
    localparam int NUM_PHASES     = 6;
    localparam int SETTLE_CYCLES  = 64;
    localparam int QUIET_LIMIT    = 4000;

    // one result word
    typedef struct packed {
        logic       led1;
        logic       led2;
        logic [7:0] duty;
        logic       pwm;
    } led_word_t;

    // one row of the directed table
    typedef struct packed {
        logic [1:0] op;
        logic [4:0] idx;
        logic       typed;
        led_word_t  want;
    } cmd_row_t;

    localparam logic TYPED   = 1'b1;
    localparam logic PREDICT = 1'b0;

    localparam led_word_t LED_11    = '{1'b1, 1'b1, 8'd0, 1'b0};
    localparam led_word_t LED_10    = '{1'b1, 1'b0, 8'd0, 1'b0};
    localparam led_word_t LED_01    = '{1'b0, 1'b1, 8'd0, 1'b0};
    localparam led_word_t LED_00    = '{1'b0, 1'b0, 8'd0, 1'b0};
    localparam led_word_t LED_PWM0  = '{1'b0, 1'b0, 8'd0, 1'b1};
    localparam led_word_t NOT_TYPED = '0;

    // phase lists: length, duration per phase, on bit per phase
    int unsigned list_len [NUM_LISTS] = '{1, 1, 2, 2, 2, 2, 2, 2, 2, 2, 4, 2, 4, 6, 10};

    int unsigned list_dur [NUM_LISTS][LIST_DEPTH] = '{
        '{3600000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{3600000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{100, 100, 0, 0, 0, 0, 0, 0, 0, 0},
        '{500, 500, 0, 0, 0, 0, 0, 0, 0, 0},
        '{800, 800, 0, 0, 0, 0, 0, 0, 0, 0},
        '{700, 700, 0, 0, 0, 0, 0, 0, 0, 0},
        '{700, 700, 0, 0, 0, 0, 0, 0, 0, 0},
        '{150, 150, 0, 0, 0, 0, 0, 0, 0, 0},
        '{150, 150, 0, 0, 0, 0, 0, 0, 0, 0},
        '{4850, 150, 0, 0, 0, 0, 0, 0, 0, 0},
        '{100, 100, 100, 1700, 0, 0, 0, 0, 0, 0},
        '{200, 1800, 0, 0, 0, 0, 0, 0, 0, 0},
        '{200, 200, 200, 1400, 0, 0, 0, 0, 0, 0},
        '{200, 200, 200, 200, 200, 1200, 0, 0, 0, 0},
        '{200, 200, 200, 200, 200, 200, 200, 200, 200, 800}
    };

    // bit i is the level of phase i
    bit [LIST_DEPTH-1:0] list_on [NUM_LISTS] = '{
        10'b0000000001, 10'b0000000000, 10'b0000000001, 10'b0000000001,
        10'b0000000001, 10'b0000000001, 10'b0000000010, 10'b0000000001,
        10'b0000000010, 10'b0000000010, 10'b0000000101, 10'b0000000001,
        10'b0000000101, 10'b0000010101, 10'b0101010101
    };

    // list used by each led for every pattern
    int unsigned pat_led1 [NUM_PATTERNS] = '{
        2, 3, 0, 5, 0, 0, 1, 4, 4, 7, 2, 3, 1, 0, 1, 1, 1, 1
    };
    int unsigned pat_led2 [NUM_PATTERNS] = '{
        2, 1, 1, 6, 9, 2, 1, 0, 10, 8, 2, 3, 1, 0, 11, 12, 13, 14
    };

    // patterns with mostly short phases, so that phase steps show up in a short burst
    logic [4:0] quick_pats [5] = '{5'd0, 5'd10, 5'd2, 5'd9, 5'd8};

    // register settings and idling of each random phase
    logic [15:0] flash_cfg  [NUM_PHASES] = '{16'd5, 16'd1, 16'd65535, 16'd0, 16'd12, 16'd3};
    logic [15:0] period_cfg [NUM_PHASES] = '{16'd40, 16'd2, 16'd65535, 16'd0, 16'd17, 16'd1};
    int send_idle_cfg  [NUM_PHASES] = '{0, 61, 0, 17, 61, 0};
    int recv_stall_cfg [NUM_PHASES] = '{0, 0, 61, 17, 0, 61};

    // directed words, run with the reset register values
    cmd_row_t directed_rows [25] = '{
        '{dlps_pkg::OP_TICK,    5'd0,  TYPED,   LED_11},
        '{dlps_pkg::OP_SELECT,  5'd0,  TYPED,   LED_11},
        '{dlps_pkg::OP_SELECT,  5'd31, TYPED,   LED_11},
        '{OP_UNUSED,            5'd21, TYPED,   LED_11},
        '{dlps_pkg::OP_TRIGGER, 5'd10, TYPED,   LED_11},
        '{dlps_pkg::OP_TICK,    5'd5,  PREDICT, NOT_TYPED},
        '{dlps_pkg::OP_SELECT,  5'd12, TYPED,   LED_PWM0},
        '{dlps_pkg::OP_TICK,    5'd31, PREDICT, NOT_TYPED},
        '{dlps_pkg::OP_TICK,    5'd0,  PREDICT, NOT_TYPED},
        '{dlps_pkg::OP_TRIGGER, 5'd31, TYPED,   LED_10},
        '{dlps_pkg::OP_TICK,    5'd3,  PREDICT, NOT_TYPED},
        '{dlps_pkg::OP_SELECT,  5'd18, PREDICT, NOT_TYPED},
        '{dlps_pkg::OP_SELECT,  5'd12, PREDICT, NOT_TYPED},
        '{dlps_pkg::OP_SELECT,  5'd17, TYPED,   LED_01},
        '{dlps_pkg::OP_SELECT,  5'd13, TYPED,   LED_11},
        '{dlps_pkg::OP_SELECT,  5'd9,  TYPED,   LED_10},
        '{dlps_pkg::OP_TICK,    5'd17, PREDICT, NOT_TYPED},
        '{dlps_pkg::OP_SELECT,  5'd4,  TYPED,   LED_10},
        '{dlps_pkg::OP_SELECT,  5'd3,  TYPED,   LED_10},
        '{dlps_pkg::OP_SELECT,  5'd6,  TYPED,   LED_00},
        '{dlps_pkg::OP_TRIGGER, 5'd0,  TYPED,   LED_10},
        '{dlps_pkg::OP_SELECT,  5'd7,  TYPED,   LED_11},
        '{OP_UNUSED,            5'd31, PREDICT, NOT_TYPED},
        '{dlps_pkg::OP_SELECT,  5'd14, TYPED,   LED_01},
        '{dlps_pkg::OP_SELECT,  5'd10, TYPED,   LED_11}
    };

    // dut signals
    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      cfg_wr_en       = 1'b0;
    logic                      cfg_addr        = 1'b0;
    logic [dlps_pkg::MS_W-1:0] cfg_wdata       = '0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_opcode        = 2'd0;
    logic [4:0]                s_pattern_index = 5'd0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic                      m_led1_on;
    logic                      m_led2_on;
    logic [7:0]                m_led1_duty;
    logic                      m_led1_pwm_mode;

    // predicted sequencer state
    logic [4:0]  pat_now;
    logic [3:0]  led1_ph, led2_ph;
    logic [21:0] led1_el, led2_el;
    logic        flash_on;
    logic [15:0] flash_el;
    logic        breathing;
    int unsigned breath_ms;
    logic        led1_lvl, led2_lvl;
    logic [15:0] flash_len_ms;
    logic [15:0] breath_period;

    // results still owed by the block, oldest first
    led_word_t leds_due [$];

    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    dual_led_pattern_sequencer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pattern_index (s_pattern_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_led1_on       (m_led1_on),
        .m_led2_on       (m_led2_on),
        .m_led1_duty     (m_led1_duty),
        .m_led1_pwm_mode (m_led1_pwm_mode)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // phase index that exists in the list, else the first phase
    function automatic logic [3:0] wrap_phase(int unsigned lst, logic [3:0] ph);
        return (ph < list_len[lst]) ? ph : 4'd0;
    endfunction

    // one millisecond of one led channel
    task automatic step_channel(input int unsigned lst, inout logic [3:0] ph,
                                inout logic [21:0] el, inout logic lvl);
        logic [3:0] p;
        p = wrap_phase(lst, ph);
        if (el != EL_SAT) el = el + 1'b1;
        if (el >= list_dur[lst][p]) begin
            p   = wrap_phase(lst, p + 4'd1);
            el  = '0;
            lvl = list_on[lst][p];
        end
        ph = p;
    endtask

    task automatic load_pattern(input logic [4:0] pat);
        pat_now   = pat;
        led1_ph   = '0;
        led2_ph   = '0;
        led1_el   = '0;
        led2_el   = '0;
        flash_on  = 1'b0;
        flash_el  = '0;
        breath_ms = 0;
        breathing = (pat == CHARGING_PAT);
        led1_lvl  = list_on[pat_led1[pat]][0];
        led2_lvl  = list_on[pat_led2[pat]][0];
    endtask

    // triangle duty from the breathing time
    function automatic logic [7:0] breath_duty();
        longint unsigned per, half, t, d;
        per  = breath_period;
        half = per / 2;
        if (half == 0) return 8'd0;
        t = breath_ms % per;
        d = (t < half) ? (t * DUTY_FULL) / half : ((per - t) * DUTY_FULL) / half;
        if (d > DUTY_FULL) d = DUTY_FULL;
        return d[7:0];
    endfunction

    task automatic run_tick();
        int unsigned l1, l2;
        l1 = pat_led1[pat_now];
        l2 = pat_led2[pat_now];
        if (breathing) begin
            breath_ms = breath_ms + 1;
            if (breath_ms >= breath_period) breath_ms = 0;
        end
        // led1 is frozen during a flash but its phase time keeps running
        if (flash_on) begin
            if (flash_el != FLASH_SAT) flash_el = flash_el + 1'b1;
            if (!breathing && led1_el != EL_SAT) led1_el = led1_el + 1'b1;
            if (flash_el >= flash_len_ms) begin
                flash_on = 1'b0;
                led1_ph  = wrap_phase(l1, led1_ph);
                led1_lvl = list_on[l1][led1_ph];
            end
        end else if (!breathing) begin
            step_channel(l1, led1_ph, led1_el, led1_lvl);
        end
        step_channel(l2, led2_ph, led2_el, led2_lvl);
    endtask

    // apply one command word and return the led word it produces
    task automatic predict_leds(input logic [1:0] op, input logic [4:0] idx,
                                output led_word_t w);
        case (op)
            dlps_pkg::OP_TICK: begin
                run_tick();
            end
            dlps_pkg::OP_SELECT: begin
                if (idx < NUM_PATTERNS && idx != pat_now) load_pattern(idx);
            end
            dlps_pkg::OP_TRIGGER: begin
                flash_on = 1'b1;
                flash_el = '0;
            end
            default: ;
        endcase
        w.led2 = led2_lvl;
        if (flash_on) begin
            w.led1 = 1'b1;
            w.duty = 8'd0;
            w.pwm  = 1'b0;
        end else if (breathing) begin
            w.led1 = 1'b0;
            w.duty = breath_duty();
            w.pwm  = 1'b1;
        end else begin
            w.led1 = led1_lvl;
            w.duty = 8'd0;
            w.pwm  = 1'b0;
        end
    endtask

    // drive one command word and record what it should produce
    task automatic send_word(input logic [1:0] op, input logic [4:0] idx,
                             input logic typed, input led_word_t want);
        int        gap;
        led_word_t guess;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_pattern_index <= idx;
        do @(posedge aclk); while (!s_ready);
        predict_leds(op, idx, guess);
        leds_due.push_back(typed ? want : guess);
    endtask

    // hold off the sender until every owed word has arrived
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (leds_due.size() != 0);
    endtask

    task automatic cfg_write(input logic addr, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        if (addr == dlps_pkg::CFG_FLASH_LEN) flash_len_ms = data;
        else breath_period = data;
    endtask

    // compare a received word with the oldest owed one
    task automatic check_result(input led_word_t got);
        led_word_t want;
        if (leds_due.size() == 0) begin
            $display("%0t: result word with none owed: led1 %0d led2 %0d duty %0d pwm %0d",
                     $time, got.led1, got.led2, got.duty, got.pwm);
            mismatches++;
        end else begin
            want = leds_due.pop_front();
            if (got.led1 !== want.led1) begin
                $display("%0t: led1_on expected %0d got %0d", $time, want.led1, got.led1);
                mismatches++;
            end
            if (got.led2 !== want.led2) begin
                $display("%0t: led2_on expected %0d got %0d", $time, want.led2, got.led2);
                mismatches++;
            end
            if (got.duty !== want.duty) begin
                $display("%0t: led1_duty expected %0d got %0d", $time, want.duty, got.duty);
                mismatches++;
            end
            if (got.pwm !== want.pwm) begin
                $display("%0t: led1_pwm_mode expected %0d got %0d", $time, want.pwm, got.pwm);
                mismatches++;
            end
        end
    endtask

    // result side: check accepted words, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_result('{m_led1_on, m_led2_on, m_led1_duty, m_led1_pwm_mode});
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin
        int         n_left;
        int         burst;
        int         r;
        logic [1:0] op;
        logic [4:0] idx;

        flash_len_ms  = 16'd50;
        breath_period = 16'd3000;
        load_pattern(5'd0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words with reset register values
        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].idx,
                      directed_rows[i].typed, directed_rows[i].want);

        // random phases: a pattern select, then a burst of mostly ticks
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge aclk);
            cfg_write(dlps_pkg::CFG_FLASH_LEN, flash_cfg[ph]);
            cfg_write(dlps_pkg::CFG_BREATH_PER, period_cfg[ph]);
            cfg_wr_en      <= 1'b0;
            send_idle_pct  = send_idle_cfg[ph];
            recv_stall_pct = recv_stall_cfg[ph];
            n_left = RAND_PER_PHASE;
            burst  = 0;
            while (n_left > 0) begin
                r = $urandom_range(99);
                if (burst == 0) begin
                    op = dlps_pkg::OP_SELECT;
                    if (r < 30) idx = 5'(CHARGING_PAT);
                    else if (r < 70) idx = quick_pats[$urandom_range(4)];
                    else idx = 5'($urandom_range(31));
                    burst = $urandom_range(180, 30);
                end else begin
                    burst--;
                    idx = 5'($urandom_range(31));
                    if (r < 86) begin
                        op = dlps_pkg::OP_TICK;
                    end else if (r < 92) begin
                        op = dlps_pkg::OP_TRIGGER;
                    end else if (r < 96) begin
                        // selects that must be ignored
                        op  = dlps_pkg::OP_SELECT;
                        idx = $urandom_range(1) ? pat_now : 5'($urandom_range(31, 18));
                    end else begin
                        op = OP_UNUSED;
                    end
                end
                if (ph == 0 && n_left == RAND_PER_PHASE / 2) drain_results();
                send_word(op, idx, PREDICT, NOT_TYPED);
                n_left--;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && leds_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
